[src/alux_pkg.sv]
// Package: shared types, constants and table functions for the lux calculator.
package alux_pkg;

    localparam int LUX_FRAC_BITS_DEF     = 8;
    localparam int POW_TABLE_ENTRIES_DEF = 64;

    localparam int COUNT_W    = 16;
    localparam int LUX_W      = 28;
    localparam int ITIME_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam int POW_W   = 17;   // r^1.4 in Q16
    localparam int COEF_W  = 32;
    localparam int PROD_W  = 49;
    localparam int PIECE_W = 44;
    localparam int DEN_W   = 45;
    localparam int GAIN_SHIFT = 4;

    localparam logic [COUNT_W-1:0] SAT_CODE = 16'hFFFF;

    // 4020 * g * 2^F / (ms10 * 1e5 * 2^16): numerator scale and denominators
    localparam logic [11:0]      SCALE_402 = 12'd4020;
    localparam logic [DEN_W-1:0] DEN_13MS  = 45'd897843200000;
    localparam logic [DEN_W-1:0] DEN_101MS = 45'd6619136000000;
    localparam logic [DEN_W-1:0] DEN_402MS = 45'd26345472000000;

    localparam logic [ITIME_W-1:0] ITIME_13MS  = 2'd0;
    localparam logic [ITIME_W-1:0] ITIME_101MS = 2'd1;
    localparam logic [ITIME_W-1:0] ITIME_402MS = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITIME = 1'b0,
        CFG_GAIN  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PIECE_POW,
        PIECE_A,
        PIECE_B,
        PIECE_C,
        PIECE_ZERO
    } piece_t;

    typedef struct packed {
        logic               sat;
        piece_t             sel;
        logic [COUNT_W-1:0] c0;
        logic [COUNT_W-1:0] c1;
    } alux_side_t;

    // Largest s below 4096 with s^5 <= v
    function automatic logic [63:0] root5(input logic [63:0] v);
        logic [63:0] s;
        logic [63:0] c;
        s = 64'd0;
        for (int b = 11; b >= 0; b--) begin
            c = s | (64'd1 << b);
            if (c * c * c * c * c <= v)
                s = c;
        end
        return s;
    endfunction

    // Table entry i of r^1.4 (Q16) at the cell midpoint (2i+1)/(4n)
    function automatic logic [POW_W-1:0] pow_entry(input int unsigned i,
                                                   input int unsigned n);
        logic [63:0] numr;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] p;
        numr = (64'(2 * i + 1)) << 30;
        q    = 64'(4 * n);
        rem  = 64'd0;
        u    = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], numr[b]};
            if (rem >= q) begin
                rem  = rem - q;
                u[b] = 1'b1;
            end
        end
        s = root5(u * u);
        p = (u * s) >> 26;
        return POW_W'(p);
    endfunction

endpackage

[src/alux_in_if.sv]
// Interface: sample channel carrying one pair of photodiode counts.
interface alux_in_if import alux_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count,
                    input ready);
    modport sink   (input valid, input broadband_count, input infrared_count,
                    output ready);
endinterface

[src/alux_out_if.sv]
// Interface: result channel carrying lux and the saturation flag.
interface alux_out_if import alux_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LUX_W-1:0] lux_value;
    logic             saturated;

    modport source (output valid, output lux_value, output saturated, input ready);
    modport sink   (input valid, input lux_value, input saturated, output ready);
endinterface

[src/ambient_light_lux_calc.sv]
// Throughput: one sample transaction per cycle; the whole pipeline advances together
// and holds while a finished result waits at the output.
// Depth is set by the ratio divider (one index bit per stage) and the lux divider
// (one overflow stage plus one quotient bit per stage for all 28 bits).
// Reset: async active low; clears valid bits, integration time to 402 ms, high gain.
module ambient_light_lux_calc import alux_pkg::*; #(
    parameter int LUX_FRAC_BITS     = LUX_FRAC_BITS_DEF,
    parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    alux_in_if.sink               sample,
    alux_out_if.source            result
);

    localparam int IDX_W = $clog2(POW_TABLE_ENTRIES);
    localparam int NUM_W = PIECE_W + 12 + GAIN_SHIFT + LUX_FRAC_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ITIME_W-1:0] itime_reg;
    logic               gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itime_reg <= ITIME_402MS;
            gain_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ITIME: itime_reg <= cfg_data[ITIME_W-1:0];
                CFG_GAIN:  gain_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global pipeline enable: every stage moves unless the output is
    // holding a result that has not been taken.
    // ---------------------------------------------------------------
    logic en;
    logic ld_valid;

    assign en           = !ld_valid || result.ready;
    assign sample.ready = en;

    // ---------------------------------------------------------------
    // Classification (feeds the ratio divider's first register).
    // Ratio bands are exact integer compares of the counts; a zero
    // broadband count falls through to the zero piece.
    // ---------------------------------------------------------------
    alux_side_t in_side;
    logic [23:0] c0w;
    logic [23:0] c1w;

    always_comb
    begin
        c0w = 24'(sample.broadband_count);
        c1w = 24'(sample.infrared_count);
        in_side.c0  = sample.broadband_count;
        in_side.c1  = sample.infrared_count;
        in_side.sat = (sample.broadband_count == SAT_CODE) ||
                      (sample.infrared_count == SAT_CODE);
        if (in_side.sat)
            in_side.sel = PIECE_ZERO;
        else if ((c1w << 1) < c0w)
            in_side.sel = PIECE_POW;
        else if (c1w * 24'd100 < c0w * 24'd61)
            in_side.sel = PIECE_A;
        else if (c1w * 24'd5 < c0w * 24'd4)
            in_side.sel = PIECE_B;
        else if (c1w * 24'd10 < c0w * 24'd13)
            in_side.sel = PIECE_C;
        else
            in_side.sel = PIECE_ZERO;
    end

    // ---------------------------------------------------------------
    // Ratio divider: table index for the r^1.4 term
    // ---------------------------------------------------------------
    logic             rd_valid;
    alux_side_t       rd_side;
    logic [IDX_W-1:0] rd_idx;

    alux_ratio_div #(
        .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .in_side   (in_side),
        .out_valid (rd_valid),
        .out_side  (rd_side),
        .out_idx   (rd_idx)
    );

    // r^1.4 table, Q16, built at elaboration
    logic [POW_W-1:0] pow_rom [POW_TABLE_ENTRIES];

    for (genvar i = 0; i < POW_TABLE_ENTRIES; i++) begin : g_pow_rom
        assign pow_rom[i] = pow_entry(i, POW_TABLE_ENTRIES);
    end

    // ---------------------------------------------------------------
    // Stage 1: per-piece coefficient (units of 1e-5, Q16 for the power piece)
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]         idx_c;
    logic [POW_W-1:0]         pow_val;
    logic [COEF_W-1:0]        pos_term;
    logic [COEF_W-1:0]        neg_term;
    logic signed [COEF_W-1:0] coef_next;

    always_comb
    begin
        idx_c = (IDX_W + 1)'(rd_idx) >= (IDX_W + 1)'(POW_TABLE_ENTRIES) ?
                IDX_W'(POW_TABLE_ENTRIES - 1) : rd_idx;
        pow_val = pow_rom[idx_c];
        case (rd_side.sel)
            PIECE_POW:
            begin
                pos_term = 32'd199229440;        // 3040 * 2^16
                neg_term = 32'd6200 * COEF_W'(pow_val);
            end
            PIECE_A:
            begin
                pos_term = 32'd2240 * COEF_W'(rd_side.c0);
                neg_term = 32'd3100 * COEF_W'(rd_side.c1);
            end
            PIECE_B:
            begin
                pos_term = 32'd1280 * COEF_W'(rd_side.c0);
                neg_term = 32'd1530 * COEF_W'(rd_side.c1);
            end
            PIECE_C:
            begin
                pos_term = 32'd146 * COEF_W'(rd_side.c0);
                neg_term = 32'd112 * COEF_W'(rd_side.c1);
            end
            default:
            begin
                pos_term = '0;
                neg_term = '0;
            end
        endcase
        coef_next = signed'(pos_term - neg_term);
    end

    logic                     s1_valid_reg;
    logic                     s1_sat_reg;
    logic                     s1_pow_reg;
    logic [COUNT_W-1:0]       s1_c0_reg;
    logic signed [COEF_W-1:0] s1_coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sat_reg  <= rd_side.sat;
            s1_pow_reg  <= (rd_side.sel == PIECE_POW);
            s1_c0_reg   <= rd_side.c0;
            s1_coef_reg <= coef_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: piece value; power piece multiplies by c0, linear pieces
    // are already in counts and only take the 2^16 factor. Negative
    // results clamp to zero.
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] prod;
    logic [PIECE_W-1:0]       piece_next;

    always_comb
    begin
        if (s1_pow_reg)
            prod = signed'({1'b0, s1_c0_reg}) * s1_coef_reg;
        else
            prod = {s1_coef_reg[COEF_W-1], s1_coef_reg, 16'b0};
        piece_next = (!prod[PROD_W-1] && (prod != '0)) ? PIECE_W'(prod) : '0;
    end

    logic               s2_valid_reg;
    logic               s2_sat_reg;
    logic [PIECE_W-1:0] s2_piece_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sat_reg   <= s1_sat_reg;
            s2_piece_reg <= piece_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: numerator = piece * 4020 * gain * 2^LUX_FRAC_BITS.
    // Unused integration code forces zero lux.
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] scaled;
    logic [NUM_W-1:0] num_next;

    always_comb
    begin
        scaled = NUM_W'(s2_piece_reg) * NUM_W'(SCALE_402);
        if (gain_reg)
            scaled = scaled << GAIN_SHIFT;
        case (itime_reg)
            ITIME_13MS, ITIME_101MS, ITIME_402MS: num_next = scaled << LUX_FRAC_BITS;
            default:                              num_next = '0;
        endcase
    end

    logic             s3_valid_reg;
    logic             s3_sat_reg;
    logic [NUM_W-1:0] s3_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sat_reg <= s2_sat_reg;
            s3_num_reg <= num_next;
        end
    end

    // Denominator ms10 * 1e5 * 2^16 for the current integration time
    logic [DEN_W-1:0] den;

    always_comb
    begin
        case (itime_reg)
            ITIME_13MS:  den = DEN_13MS;
            ITIME_101MS: den = DEN_101MS;
            default:     den = DEN_402MS;
        endcase
    end

    // ---------------------------------------------------------------
    // Lux divider; its last register is the output register
    // ---------------------------------------------------------------
    logic             ld_sat;
    logic [LUX_W-1:0] ld_lux;

    alux_lux_div #(
        .NUM_W (NUM_W)
    ) u_lux_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_sat    (s3_sat_reg),
        .in_num    (s3_num_reg),
        .den       (den),
        .out_valid (ld_valid),
        .out_sat   (ld_sat),
        .out_lux   (ld_lux)
    );

    assign result.valid     = ld_valid;
    assign result.lux_value = ld_lux;
    assign result.saturated = ld_sat;

endmodule

[src/alux_ratio_div.sv]
// Pipelined restoring divider: table index floor(c1 * 2N / c0), one bit per stage.
module alux_ratio_div import alux_pkg::*; #(
    parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(POW_TABLE_ENTRIES),
    localparam int NR_W  = COUNT_W + $clog2(2 * POW_TABLE_ENTRIES) + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  alux_side_t       in_side,
    output logic             out_valid,
    output alux_side_t       out_side,
    output logic [IDX_W-1:0] out_idx
);

    logic             vld_reg  [IDX_W+1];
    alux_side_t       side_reg [IDX_W+1];
    logic [NR_W-1:0]  rem_reg  [IDX_W+1];
    logic [IDX_W-1:0] q_reg    [IDX_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            rem_reg[0]  <= NR_W'(in_side.c1) * NR_W'(2 * POW_TABLE_ENTRIES);
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 0; j < IDX_W; j++) begin : g_stage
        localparam int K = IDX_W - 1 - j;
        logic [NR_W-1:0]  trial;
        logic             ge;
        logic [NR_W-1:0]  rem_next;
        logic [IDX_W-1:0] q_next;

        always_comb
        begin
            trial    = NR_W'(side_reg[j].c0) << K;
            ge       = (rem_reg[j] >= trial);
            rem_next = ge ? (rem_reg[j] - trial) : rem_reg[j];
            q_next   = q_reg[j];
            q_next[K] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j+1] <= side_reg[j];
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[IDX_W];
    assign out_side  = side_reg[IDX_W];
    assign out_idx   = q_reg[IDX_W];

endmodule

[src/alux_lux_div.sv]
// Pipelined restoring divider: lux = floor(num / den), saturating at the lux width.
module alux_lux_div import alux_pkg::*; #(
    parameter int NUM_W = 60 + LUX_FRAC_BITS_DEF,
    localparam int DW = (NUM_W > DEN_W + LUX_W) ? NUM_W : DEN_W + LUX_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic             in_sat,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic             out_sat,
    output logic [LUX_W-1:0] out_lux
);

    logic             vld_reg [LUX_W+1];
    logic             sat_reg [LUX_W+1];
    logic             ovf_reg [LUX_W+1];
    logic [DW-1:0]    rem_reg [LUX_W+1];
    logic [LUX_W-1:0] q_reg   [LUX_W+1];

    logic [DW-1:0] den_w;
    assign den_w = DW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    // quotient too large for the lux field when num >= den * 2^LUX_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= in_sat;
            ovf_reg[0] <= (DW'(in_num) >= (den_w << LUX_W));
            rem_reg[0] <= DW'(in_num);
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < LUX_W; j++) begin : g_stage
        localparam int K = LUX_W - 1 - j;
        logic [DW-1:0]    trial;
        logic             ge;
        logic [DW-1:0]    rem_next;
        logic [LUX_W-1:0] q_next;

        always_comb
        begin
            trial    = den_w << K;
            ge       = (rem_reg[j] >= trial);
            rem_next = ge ? (rem_reg[j] - trial) : rem_reg[j];
            q_next   = q_reg[j];
            q_next[K] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[j+1] <= sat_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                rem_reg[j+1] <= rem_next;
                q_reg[j+1]   <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[LUX_W];
    assign out_sat   = sat_reg[LUX_W];
    assign out_lux   = ovf_reg[LUX_W] ? {LUX_W{1'b1}} : q_reg[LUX_W];

endmodule

[src/alux_checker.sv]
// Checker: port-level assertions for the lux calculator, bound to the top level.
module alux_checker import alux_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [LUX_W-1:0] out_lux,
    input logic             out_sat
);

    // a saturated reading never reports light
    a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_sat |-> out_lux == '0)
        else $error("saturated result with nonzero lux");

    // a waiting result stalls the sample side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample accepted while result stalled");

    // with nothing waiting at the output the block takes samples
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("sample side blocked with empty output");

    // an offered sample always sees a defined ready
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("sample ready unknown while a sample is offered");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_lux) && $stable(out_sat))
        else $error("stalled result changed");

endmodule

bind ambient_light_lux_calc alux_checker u_alux_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_lux   (result.lux_value),
    .out_sat   (result.saturated)
);

[tb/ambient_light_lux_calc_tb.sv]
// Self-checking testbench for the two-channel photodiode lux calculator.
module ambient_light_lux_calc_tb import alux_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS     = 8;
    localparam int POW_ENTRIES   = 64;
    localparam int PIPE_LATENCY  = 39;        // registers between sample and result
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 10;
    localparam int STALL_LIMIT   = 5000;      // cycles with no transaction on either side
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PAIRS   = 205;
    localparam int IDLE_PCT      = 31;

    // itime code that the block treats as invalid (lux forced to zero)
    localparam logic [ITIME_W-1:0] ITIME_BAD = 2'd3;
    localparam logic [COUNT_W-1:0] NEAR_FULL = 16'hFFFE;
    localparam logic [LUX_W-1:0]   LUX_CLAMP = '1;

    typedef struct {
        logic [LUX_W-1:0] lux;
        logic             sat;
    } lux_reading_t;

    // directed row: counts, plus a hand-written expectation where it is obvious
    typedef struct {
        logic [COUNT_W-1:0] bb;
        logic [COUNT_W-1:0] ir;
        bit                 fixed;
        logic [LUX_W-1:0]   lux;
        logic               sat;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ITIME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    alux_in_if  sample_ch ();
    alux_out_if result_ch ();

    ambient_light_lux_calc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #10 clk = ~clk;

    // Shadow of the block's registers, updated only when the pipe is empty
    logic [ITIME_W-1:0] model_itime = ITIME_402MS;
    logic               model_low_gain = 1'b0;

    // r^1.4 lookup in Q16, one entry per ratio cell, sampled at cell midpoints
    longint unsigned pow_q16 [POW_ENTRIES];

    lux_reading_t pending_lux [$];      // expected readings, oldest first
    int  error_count = 0;
    int  pairs_sent = 0;
    int  readings_checked = 0;
    int  sat_seen = 0;
    int  clamp_seen = 0;
    bit  steady_flow = 1'b0;            // when set, neither side idles

    // Fifth root, floor, searched bit by bit from the top
    function automatic longint unsigned fifth_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 11; b >= 0; b--) begin
            t = r + (longint'(1) << b);
            if (t * t * t * t * t <= v)
                r = t;
        end
        return r;
    endfunction

    initial begin
        longint unsigned mid_q30;
        for (int i = 0; i < POW_ENTRIES; i++) begin
            // x = (2i+1)/(4N) in Q30; x^1.4 = x * (x^2)^(1/5)
            mid_q30 = (longint'(2 * i + 1) << 30) / longint'(4 * POW_ENTRIES);
            pow_q16[i] = (mid_q30 * fifth_root(mid_q30 * mid_q30)) >> 26;
        end
    end

    // Expected reading for one pair of counts under the current register shadow
    function automatic lux_reading_t lux_expected(input logic [COUNT_W-1:0] bb,
                                                  input logic [COUNT_W-1:0] ir);
        lux_reading_t    rd;
        longint          c0;
        longint          c1;
        longint          piece;
        longint unsigned tbl_idx;
        longint unsigned ms10;
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned rem;
        c0 = longint'(bb);
        c1 = longint'(ir);
        rd.sat = (bb == SAT_CODE) || (ir == SAT_CODE);
        rd.lux = '0;
        case (model_itime)
            ITIME_13MS:  ms10 = 137;
            ITIME_101MS: ms10 = 1010;
            ITIME_402MS: ms10 = 4020;
            default:     ms10 = 0;
        endcase
        if (rd.sat || ms10 == 0 || c0 == 0)
            return rd;
        // coefficients in units of 1e-5, piece scaled by 2^16
        if (2 * c1 < c0) begin
            tbl_idx = longint'(c1 * 2 * POW_ENTRIES) / c0;
            if (tbl_idx >= POW_ENTRIES)
                tbl_idx = POW_ENTRIES - 1;
            piece = c0 * (3040 * 65536 - 6200 * longint'(pow_q16[tbl_idx]));
        end else if (100 * c1 < 61 * c0)
            piece = (2240 * c0 - 3100 * c1) * 65536;
        else if (5 * c1 < 4 * c0)
            piece = (1280 * c0 - 1530 * c1) * 65536;
        else if (10 * c1 < 13 * c0)
            piece = (146 * c0 - 112 * c1) * 65536;
        else
            piece = 0;
        if (piece <= 0)
            return rd;
        num = longint'(piece) * 4020 * (model_low_gain ? 16 : 1);
        den = ms10 * 100000 * 65536;
        quo = num / den;
        rem = num % den;
        // fraction bits by restoring division, truncated
        for (int b = 0; b < FRAC_BITS; b++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        rd.lux = (quo > longint'(LUX_CLAMP)) ? LUX_CLAMP : LUX_W'(quo);
        return rd;
    endfunction

    // Input side: every accepted pair gets its expectation queued
    always @(posedge clk) begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            pending_lux.push_back(lux_expected(sample_ch.broadband_count,
                                               sample_ch.infrared_count));
    end

    // Output side: compare against the oldest expectation
    always @(posedge clk) begin
        lux_reading_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_lux.size() == 0) begin
                $error("unexpected result transaction: lux_value=%0d saturated=%0b",
                       result_ch.lux_value, result_ch.saturated);
                error_count++;
            end else begin
                want = pending_lux.pop_front();
                if (result_ch.lux_value !== want.lux) begin
                    $error("lux_value mismatch: expected %0d, actual %0d",
                           want.lux, result_ch.lux_value);
                    error_count++;
                end
                if (result_ch.saturated !== want.sat) begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           want.sat, result_ch.saturated);
                    error_count++;
                end
                readings_checked++;
                sat_seen += want.sat;
                clamp_seen += (want.lux == LUX_CLAMP);
            end
        end
    end

    // Receiver back-pressure, off while steady_flow is set
    always @(posedge clk) begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: count cycles where nothing moves on either channel
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one pair and hold it until the block takes it.
    // Random gaps are inserted before valid rises; valid stays high across
    // back-to-back pairs without being dropped in between.
    task automatic send_pair(input logic [COUNT_W-1:0] bb, input logic [COUNT_W-1:0] ir);
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                sample_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.broadband_count <= bb;
        sample_ch.infrared_count <= ir;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Let the pipe empty, then update both registers and the shadow copy
    task automatic write_config(input logic [ITIME_W-1:0] itime, input logic gain_bit,
                                input logic junk_bit);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_lux.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ITIME;
        cfg_data <= CFG_DATA_W'(itime);
        @(posedge clk);
        cfg_index <= CFG_GAIN;
        cfg_data <= {junk_bit, gain_bit};   // upper bit must be masked off
        @(posedge clk);
        cfg_we <= 1'b0;
        model_itime = itime;
        model_low_gain = gain_bit;
    endtask

    // Random pair biased toward the interesting regions of the lux formula
    task automatic random_pair(output logic [COUNT_W-1:0] bb, output logic [COUNT_W-1:0] ir);
        int unsigned pick;
        longint unsigned scaled;
        pick = $urandom_range(99);
        if (pick < 15)
            bb = COUNT_W'($urandom_range(1, 255));
        else if (pick < 25)
            bb = COUNT_W'($urandom_range(16'hF000, 16'hFFFE));
        else
            bb = COUNT_W'($urandom_range(0, 16'hFFFE));
        pick = $urandom_range(99);
        if (pick < 70) begin
            // ratio spread over [0, 1.5] to visit every piece and the cutoff
            scaled = (longint'(bb) * $urandom_range(0, 1500)) / 1000;
            ir = (scaled > NEAR_FULL) ? NEAR_FULL : COUNT_W'(scaled);
        end else
            ir = COUNT_W'($urandom_range(0, 16'hFFFE));
        pick = $urandom_range(99);
        if (pick < 4)
            bb = SAT_CODE;
        else if (pick < 8)
            ir = SAT_CODE;
        else if (pick < 12)
            bb = '0;
    endtask

    // Directed pairs at the reset setting (402 ms, high gain)
    directed_row_t directed [] = '{
        '{16'd0,     16'd0,     1'b1, 28'd0, 1'b0},   // dark
        '{SAT_CODE,  16'd0,     1'b1, 28'd0, 1'b1},   // broadband saturated
        '{16'd0,     SAT_CODE,  1'b1, 28'd0, 1'b1},   // infrared saturated
        '{SAT_CODE,  SAT_CODE,  1'b1, 28'd0, 1'b1},
        '{16'd0,     16'd1234,  1'b1, 28'd0, 1'b0},   // zero broadband
        '{16'd100,   16'd130,   1'b1, 28'd0, 1'b0},   // ratio exactly 1.30
        '{16'd100,   16'd200,   1'b1, 28'd0, 1'b0},   // ratio above cutoff
        '{NEAR_FULL, 16'd0,     1'b0, 28'd0, 1'b0},   // largest lux at this setting
        '{NEAR_FULL, 16'h7FFE,  1'b0, 28'd0, 1'b0},   // just under ratio 0.5
        '{16'd1000,  16'd499,   1'b0, 28'd0, 1'b0},
        '{16'd1000,  16'd500,   1'b0, 28'd0, 1'b0},   // piece boundaries
        '{16'd1000,  16'd609,   1'b0, 28'd0, 1'b0},
        '{16'd1000,  16'd610,   1'b0, 28'd0, 1'b0},
        '{16'd1000,  16'd799,   1'b0, 28'd0, 1'b0},
        '{16'd1000,  16'd800,   1'b0, 28'd0, 1'b0},
        '{16'd1000,  16'd1299,  1'b0, 28'd0, 1'b0},
        '{16'd1,     16'd0,     1'b0, 28'd0, 1'b0},
        '{16'd1,     16'd1,     1'b0, 28'd0, 1'b0},
        '{NEAR_FULL, NEAR_FULL, 1'b0, 28'd0, 1'b0},
        '{16'h5555,  16'h2AAA,  1'b0, 28'd0, 1'b0},   // alternating bit patterns
        '{16'hAAAA,  16'h5555,  1'b0, 28'd0, 1'b0},
        '{16'd2,     16'd1,     1'b0, 28'd0, 1'b0}
    };

    // Register settings per random phase: all codes, both gains, extremes
    // (13.7 ms with low gain gives the largest lux; code 3 zeroes lux)
    logic [ITIME_W-1:0] phase_itime [RANDOM_PHASES] = '{
        ITIME_13MS, ITIME_101MS, ITIME_402MS, ITIME_BAD,
        ITIME_13MS, ITIME_402MS, ITIME_101MS, ITIME_BAD
    };
    logic phase_gain [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    initial begin
        logic [COUNT_W-1:0] bb;
        logic [COUNT_W-1:0] ir;
        lux_reading_t want;
        sample_ch.valid = 1'b0;
        sample_ch.broadband_count = '0;
        sample_ch.infrared_count = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            if (directed[k].fixed) begin
                // hand-written value must agree with the predictor as well
                want = lux_expected(directed[k].bb, directed[k].ir);
                if (want.lux !== directed[k].lux || want.sat !== directed[k].sat) begin
                    $error("directed row %0d: table and predictor disagree", k);
                    error_count++;
                end
            end
            send_pair(directed[k].bb, directed[k].ir);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_config(phase_itime[ph], phase_gain[ph], 1'($urandom_range(1)));
            steady_flow = (ph == 2);   // one phase runs flat out on both sides
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                random_pair(bb, ir);
                send_pair(bb, ir);
            end
            steady_flow = 1'b0;
        end

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_lux.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d count pairs over %0d register settings; checked %0d readings",
                 pairs_sent, RANDOM_PHASES + 1, readings_checked);
        $display("  saturated readings: %0d, lux at clamp: %0d", sat_seen, clamp_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[ambient_light_lux_calc.f]
src/alux_pkg.sv
src/alux_in_if.sv
src/alux_out_if.sv
src/alux_ratio_div.sv
src/alux_lux_div.sv
src/ambient_light_lux_calc.sv
src/alux_checker.sv
tb/ambient_light_lux_calc_tb.sv
